// ----- rtl/pctrb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pctrb_pkg: shared types and constants of the per-CPU trace ring buffer
// Field widths, operation, class and result codes, register indexes, the
// stored record layout and the controller/datapath command and status groups.
// ----------------------------------------------------------------------------
package pctrb_pkg;

  // Field widths
  localparam int FUNC_W      = 3;
  localparam int CPU_W       = 4;
  localparam int EVID_W      = 32;
  localparam int CLASS_W     = 3;
  localparam int COUNT_W     = 8;
  localparam int PAYLOAD_W   = 64;
  localparam int TS_W        = 64;
  localparam int IDX_W       = 8;
  localparam int RC_W        = 3;
  localparam int RING_FILL_W = 9;
  localparam int LOST_W      = 64;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0]  REG_CLASS_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_CPUS_IN_USE  = 1'd1;
  localparam logic [CFG_DATA_W-1:0] CPUS_IN_USE_RST  = 4'd8;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_PUT    = 3'd0;
  localparam logic [FUNC_W-1:0] FN_READ   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_STATUS = 3'd2;
  localparam logic [FUNC_W-1:0] FN_START  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_STOP   = 3'd4;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd5;

  // Event classes
  localparam logic [CLASS_W-1:0] CLS_TIMER     = 3'd1;
  localparam logic [CLASS_W-1:0] CLS_SCHED     = 3'd2;
  localparam logic [CLASS_W-1:0] CLS_VM        = 3'd3;
  localparam logic [CLASS_W-1:0] CLS_HYPERCALL = 3'd4;

  // Result codes
  localparam logic [RC_W-1:0] RC_OK       = 3'd0;
  localparam logic [RC_W-1:0] RC_DROP     = 3'd1;
  localparam logic [RC_W-1:0] RC_BUSY     = 3'd2;
  localparam logic [RC_W-1:0] RC_BADMASK  = 3'd3;
  localparam logic [RC_W-1:0] RC_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    logic [CPU_W-1:0]     cpu_id;
    logic [EVID_W-1:0]    event_id;
    logic [CLASS_W-1:0]   event_class;
    logic [COUNT_W-1:0]   data_count;
    logic [PAYLOAD_W-1:0] payload_low;
    logic [PAYLOAD_W-1:0] payload_high;
    logic [TS_W-1:0]      timestamp;
    logic [IDX_W-1:0]     record_index;
  } req_item_t;

  typedef struct packed {
    logic [RC_W-1:0]        result_code;
    logic [TS_W-1:0]        rec_timestamp;
    logic [EVID_W-1:0]      rec_event_id;
    logic [COUNT_W-1:0]     rec_data_count;
    logic [CPU_W-1:0]       rec_cpu;
    logic [PAYLOAD_W-1:0]   rec_payload_low;
    logic [PAYLOAD_W-1:0]   rec_payload_high;
    logic [RING_FILL_W-1:0] ring_fill;
    logic [LOST_W-1:0]      overwrite_total;
  } rsp_item_t;

  // One stored trace record
  typedef struct packed {
    logic [TS_W-1:0]      ts;
    logic [EVID_W-1:0]    id;
    logic [COUNT_W-1:0]   count;
    logic [CPU_W-1:0]     cpu;
    logic [PAYLOAD_W-1:0] lo;
    logic [PAYLOAD_W-1:0] hi;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // Controller to datapath
  typedef struct packed {
    logic load_item;    // transaction accepted, latch item, read ring state
    logic exec;         // decide, commit state updates, issue record read
    logic rec_capture;  // record read data valid, take into result
    logic out_load;     // move result into the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_rec;     // item is a record read that hits
    logic out_busy;     // output register holds a transaction not yet taken
  } dp_sts_t;

endpackage
`default_nettype wire

// ----- rtl/pctrb_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pctrb_in_if: request channel
// Valid/ready channel carrying one operation item.
// ----------------------------------------------------------------------------
interface pctrb_in_if import pctrb_pkg::*; ();
  logic      valid;
  logic      ready;
  req_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/pctrb_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pctrb_out_if: response channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface pctrb_out_if import pctrb_pkg::*; ();
  logic      valid;
  logic      ready;
  rsp_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/pctrb_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pctrb_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pctrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/pctrb_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pctrb_ctrl: operation sequencer
// Steps one item through accept, execute, optional record read and result
// hand-off to the output register.
// ----------------------------------------------------------------------------
module pctrb_ctrl import pctrb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      in_ready,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_REC  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state, state_next;

  // Commands
  assign in_ready        = (state == S_IDLE) && !rst;
  assign cmd.load_item   = in_ready && req_valid;
  assign cmd.exec        = (state == S_EXEC);
  assign cmd.rec_capture = (state == S_REC);
  assign cmd.out_load    = (state == S_OUT) && !sts.out_busy;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.load_item) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = sts.need_rec ? S_REC : S_OUT;
      end
      S_REC: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_busy) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef NO_ASSERTIONS
  // An accepted transaction is executed in the next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.load_item |=> cmd.exec)
    else $error("accepted item not executed next cycle");

  // A hitting record read always gets its capture cycle
  a_rec_follow: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && sts.need_rec |=> cmd.rec_capture)
    else $error("record read without capture");

  // Non-read items skip the capture cycle
  a_no_rec: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && !sts.need_rec |=> !cmd.rec_capture)
    else $error("spurious record capture");
`endif

endmodule
`default_nettype wire

// ----- rtl/pctrb_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pctrb_dp: trace buffer datapath
// Config registers, per-ring state RAM with valid bits, record RAM, the
// operation decision logic, result register and output register.
// ----------------------------------------------------------------------------
module pctrb_dp import pctrb_pkg::*; #(
  parameter int NUM_CPUS   = 8,
  parameter int RING_DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  req_item_t             req_data,
  pctrb_out_if.source           rsp,
  input  ctrl_cmd_t             cmd,
  output dp_sts_t               sts
);

  localparam int CW  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int NR  = 1 << CW;
  localparam int PW  = $clog2(RING_DEPTH);
  localparam int FW  = $clog2(RING_DEPTH + 1);
  localparam int AW  = CW + PW;
  localparam int SW  = ((PW > IDX_W) ? PW : IDX_W) + 1;
  localparam int XW  = (FW > IDX_W) ? FW : IDX_W;
  localparam int LW  = ($clog2(NUM_CPUS + 1) > CPU_W) ? $clog2(NUM_CPUS + 1) : CPU_W;
  localparam int RSW = PW + FW + LOST_W;

  // Config registers
  logic [CFG_DATA_W-1:0] class_enable;
  logic [CFG_DATA_W-1:0] cpus_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      class_enable <= '0;
      cpus_in_use  <= CPUS_IN_USE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CLASS_ENABLE: class_enable <= cfg_data;
        REG_CPUS_IN_USE:  cpus_in_use  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Item register
  req_item_t itm;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      itm <= req_data;
    end
  end

  logic          running;
  logic [NR-1:0] ring_valid;
  logic [CW-1:0] cpu;
  logic [LW-1:0] lim;
  logic          active;

  assign cpu    = CW'(itm.cpu_id);
  assign lim    = (LW'(cpus_in_use) > LW'(NUM_CPUS)) ? LW'(NUM_CPUS) : LW'(cpus_in_use);
  assign active = LW'(itm.cpu_id) < lim;

  // Per-ring state RAM, read at accept; invalid rings read as empty
  logic           rs_we;
  logic [RSW-1:0] rs_wdata;
  logic [RSW-1:0] rs_rdata;
  logic [PW-1:0]  wpos;
  logic [FW-1:0]  fill;
  logic [LOST_W-1:0] lost;

  pctrb_ram #(.WIDTH(RSW), .DEPTH(NR)) u_ring_ram (
    .clk   (clk),
    .we    (rs_we),
    .waddr (cpu),
    .wdata (rs_wdata),
    .re    (cmd.load_item),
    .raddr (CW'(req_data.cpu_id)),
    .rdata (rs_rdata)
  );

  assign {wpos, fill, lost} = ring_valid[cpu] ? rs_rdata : '0;

  // Class filter
  logic cls_en;

  always_comb begin
    case (itm.event_class)
      CLS_TIMER:     cls_en = class_enable[0];
      CLS_SCHED:     cls_en = class_enable[1];
      CLS_VM:        cls_en = class_enable[2];
      CLS_HYPERCALL: cls_en = class_enable[3];
      default:       cls_en = 1'b0;
    endcase
  end

  // Put: advance write position, grow fill or count an overwrite
  logic          put_ok;
  logic          full;
  logic [PW-1:0] wpos_next;
  logic [FW-1:0] wr_fill;
  logic [LOST_W-1:0] wr_lost;

  assign put_ok    = (itm.func == FN_PUT) && running && cls_en && active;
  assign full      = (fill == FW'(RING_DEPTH));
  assign wpos_next = (wpos == PW'(RING_DEPTH - 1)) ? '0 : wpos + 1'b1;
  assign wr_fill   = full ? fill : fill + 1'b1;
  assign wr_lost   = full ? lost + 1'b1 : lost;
  assign rs_we     = cmd.exec && put_ok;
  assign rs_wdata  = {wpos_next, wr_fill, wr_lost};

  // Read: map chronological index to ring slot
  logic          idx_hit;
  logic [PW-1:0] oldest;
  logic [SW-1:0] slot_sum;
  logic [PW-1:0] slot;
  logic          rd_ok;
  logic          rec_re;

  assign idx_hit  = XW'(itm.record_index) < XW'(fill);
  assign oldest   = full ? wpos : '0;
  assign slot_sum = SW'(oldest) + SW'(itm.record_index);
  assign slot     = (slot_sum >= SW'(RING_DEPTH)) ? PW'(slot_sum - SW'(RING_DEPTH))
                                                  : PW'(slot_sum);
  assign rd_ok    = (itm.func == FN_READ) && !running && active && idx_hit;
  assign rec_re   = cmd.exec && rd_ok;

  // Record RAM
  rec_t rec_wdata;
  rec_t rec_rdata;

  assign rec_wdata.ts    = itm.timestamp;
  assign rec_wdata.id    = itm.event_id;
  assign rec_wdata.count = itm.data_count;
  assign rec_wdata.cpu   = itm.cpu_id;
  assign rec_wdata.lo    = itm.payload_low;
  assign rec_wdata.hi    = itm.payload_high;

  pctrb_ram #(.WIDTH(REC_W), .DEPTH(1 << AW)) u_rec_ram (
    .clk   (clk),
    .we    (rs_we),
    .waddr ({cpu, wpos}),
    .wdata (rec_wdata),
    .re    (rec_re),
    .raddr ({cpu, slot}),
    .rdata (rec_rdata)
  );

  // Result code
  logic [RC_W-1:0] rc;

  always_comb begin
    case (itm.func)
      FN_PUT:    rc = put_ok ? RC_OK : RC_DROP;
      FN_READ:   rc = running ? RC_BUSY : ((active && idx_hit) ? RC_OK : RC_NOTFOUND);
      FN_STATUS: rc = active ? RC_OK : RC_NOTFOUND;
      FN_START:  rc = (class_enable == '0) ? RC_BADMASK : (running ? RC_BUSY : RC_OK);
      FN_STOP:   rc = RC_OK;
      FN_CLEAR:  rc = running ? RC_BUSY : RC_OK;
      default:   rc = RC_DROP;
    endcase
  end

  logic rings_clear;
  logic status_ok;

  assign rings_clear = cmd.exec && (rc == RC_OK) &&
                       ((itm.func == FN_START) || (itm.func == FN_CLEAR));
  assign status_ok   = (itm.func == FN_STATUS) && active;

  // Capture flag and ring valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      running    <= 1'b0;
      ring_valid <= '0;
    end else begin
      if (cmd.exec && (itm.func == FN_START) && (rc == RC_OK)) begin
        running <= 1'b1;
      end else if (cmd.exec && (itm.func == FN_STOP)) begin
        running <= 1'b0;
      end
      if (rings_clear) begin
        ring_valid <= '0;
      end else if (rs_we) begin
        ring_valid[cpu] <= 1'b1;
      end
    end
  end

  // Result register: code and status at execute, record fields at capture
  rsp_item_t res;
  rsp_item_t res_next;

  always_comb begin
    res_next = res;
    if (cmd.exec) begin
      res_next             = '0;
      res_next.result_code = rc;
      if (status_ok) begin
        res_next.ring_fill       = RING_FILL_W'(fill);
        res_next.overwrite_total = lost;
      end
    end else if (cmd.rec_capture) begin
      res_next.rec_timestamp    = rec_rdata.ts;
      res_next.rec_event_id     = rec_rdata.id;
      res_next.rec_data_count   = rec_rdata.count;
      res_next.rec_cpu          = rec_rdata.cpu;
      res_next.rec_payload_low  = rec_rdata.lo;
      res_next.rec_payload_high = rec_rdata.hi;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.data <= res;
    end
  end

  assign sts.need_rec = rd_ok;
  assign sts.out_busy = rsp.valid && !rsp.ready;

`ifndef NO_ASSERTIONS
  // Records are only written while capture runs
  a_put_running: assert property (@(posedge clk) disable iff (rst)
    rs_we |-> running)
    else $error("record written while stopped");

  // Fill level never passes the ring depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    rs_we |-> (wr_fill <= FW'(RING_DEPTH)))
    else $error("fill level beyond ring depth");

  // Capture only follows an issued record read
  a_rec_issued: assert property (@(posedge clk) disable iff (rst)
    cmd.rec_capture |-> $past(rec_re))
    else $error("record capture without read");
`endif

endmodule
`default_nettype wire

// ----- rtl/per_cpu_trace_ring_buffer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// per_cpu_trace_ring_buffer: per-CPU overwriting trace ring buffer
// One ring of trace records per CPU with put, read, status, start, stop and
// clear operations; full rings overwrite the oldest record.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    req_item_t (operation item)
//   rsp      out  valid/ready    rsp_item_t (one result per item)
//   cfg      in   cfg_we only    cfg_index, cfg_data
//
// One item at a time: the item passes through the execute step, a record read
// step for record reads (registered record RAM read) and the output load step.
// The next item is accepted from idle after the result is loaded, so a new
// item is not taken before the last one is through.
// Synchronous reset; no clearing pass, rings are emptied through valid bits.
// A stalled output holds the sequencer before the load step.
// ----------------------------------------------------------------------------
module per_cpu_trace_ring_buffer import pctrb_pkg::*; #(
  parameter int NUM_CPUS   = 8,
  parameter int RING_DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  pctrb_in_if.sink              req,
  pctrb_out_if.source           rsp
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;
  logic      in_ready;

  assign req.ready = in_ready;

  pctrb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pctrb_dp #(
    .NUM_CPUS   (NUM_CPUS),
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_data  (req.data),
    .rsp       (rsp),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
`default_nettype wire
